/* rtl/ptbf_pkg.sv */
// Shared types, constants and colour helpers for the pixel to bit-plane framebuffer.
package ptbf_pkg;

   localparam int COORD_W  = 10;
   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int WADDR_W  = 15;
   localparam int WDATA_W  = 6;

   // Quantisation step for one 8-bit channel (255 / 3)
   localparam logic [CHAN_W-1:0] CHAN_STEP = 8'd85;

   // Plane masks: LSB plane bits and MSB plane bits of the packed colour
   localparam logic [WDATA_W-1:0] PLANE_LO_MASK = 6'h15;
   localparam logic [WDATA_W-1:0] PLANE_HI_MASK = 6'h2A;

   // Control carried with one byte update
   typedef struct packed {
      logic                last;       // MSB-plane update, second of the pair
      logic                high_half;  // even flipped row: bits 5,3,1
      logic [WDATA_W-1:0]  plane;      // plane bits at positions 4,2,0
   } op_ctl_type;

   // Channel value divided by 85, giving 0..3
   function automatic logic [1:0] quant_chan(input logic [CHAN_W-1:0] v);
      logic [1:0] q;
      if (v == 8'hFF) begin
         q = 2'd3;
      end else if (v >= CHAN_STEP + CHAN_STEP) begin
         q = 2'd2;
      end else if (v >= CHAN_STEP) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

endpackage

/* rtl/pixel_to_bitplane_framebuffer.sv */
// Each on-grid pixel makes two byte updates through the store ports; the next pixel is
// accepted as the store takes the second. The LSB-plane beat passes the issue, store and
// output beat registers, the MSB-plane beat after it. Off-grid pixels are taken, no beat.
// Reset: synchronous; afterwards a clearing sweep writes zero to all COLS*ROWS bytes,
// one per cycle, and no pixel is accepted until it finishes.
module pixel_to_bitplane_framebuffer #(
   parameter int COLS = 144,
   parameter int ROWS = 168
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_col,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_row,
   input  logic        [ptbf_pkg::COLOR_W-1:0] req_color_rgb,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [ptbf_pkg::WADDR_W-1:0] rsp_write_addr,
   output logic        [ptbf_pkg::WDATA_W-1:0] rsp_write_data,
   output logic                                rsp_last_write
);
   import ptbf_pkg::*;

   localparam int AddrW = $clog2(COLS * ROWS);

   logic               clearing;
   logic               op_valid, op_ready;
   logic [AddrW-1:0]   op_addr;
   op_ctl_type         op_ctl;
   logic               out_free;
   logic               res_valid, res_last;
   logic [AddrW-1:0]   res_addr;
   logic [WDATA_W-1:0] res_data;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WADDR_W-1:0] rsp_addr_ff;
   logic [WDATA_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   ptbf_issue #(.COLS(COLS), .ROWS(ROWS), .AddrW(AddrW)) u_issue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .req_color_rgb (req_color_rgb),
      .clearing      (clearing),
      .op_ready      (op_ready),
      .op_valid      (op_valid),
      .op_addr       (op_addr),
      .op_ctl        (op_ctl)
   );

   ptbf_store #(.COLS(COLS), .ROWS(ROWS), .AddrW(AddrW)) u_store (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_addr   (op_addr),
      .op_ctl    (op_ctl),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_addr  (res_addr),
      .res_data  (res_data),
      .res_last  (res_last)
   );

   // Output beat register: load when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_addr_ff <= WADDR_W'(res_addr);
         rsp_data_ff <= res_data;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_addr = rsp_addr_ff;
   assign rsp_write_data = rsp_data_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule

/* rtl/ptbf_issue.sv */
// Pixel intake: bound check, colour split, row flip and two-beat address sequencing.
module ptbf_issue #(
   parameter int COLS  = 144,
   parameter int ROWS  = 168,
   parameter int AddrW = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_col,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_row,
   input  logic        [ptbf_pkg::COLOR_W-1:0] req_color_rgb,
   input  logic                                clearing,
   input  logic                                op_ready,
   output logic                                op_valid,
   output logic        [AddrW-1:0]             op_addr,
   output ptbf_pkg::op_ctl_type                op_ctl
);
   import ptbf_pkg::*;

   localparam logic [COORD_W:0]   ColsLim  = (COORD_W+1)'(COLS);
   localparam logic [COORD_W:0]   RowsLim  = (COORD_W+1)'(ROWS);
   localparam logic [COORD_W-2:0] RowLast  = (COORD_W-1)'(ROWS - 1);
   localparam logic [AddrW-1:0]   RowsA    = AddrW'(ROWS);
   localparam logic [AddrW-1:0]   HalfRows = AddrW'(ROWS / 2);

   logic                 s0_valid_ff, s0_valid_in;
   logic                 phase_ff, phase_in;
   logic [AddrW-1:0]     base_ff, base_in;
   logic [COORD_W-3:0]   half_row_ff;
   logic                 high_ff;
   logic [WDATA_W-1:0]   lsb_ff, msb_ff;

   logic                 req_fire, op_fire, pix_ok;
   logic [COORD_W-2:0]   flip_row;
   logic [WDATA_W-1:0]   color6;

   // Decode the incoming pixel
   always_comb begin
      pix_ok   = !req_pixel_col[COORD_W-1]
                 && ({2'b00, req_pixel_col[COORD_W-2:0]} < ColsLim)
                 && !req_pixel_row[COORD_W-1]
                 && ({2'b00, req_pixel_row[COORD_W-2:0]} < RowsLim);
      flip_row = RowLast - req_pixel_row[COORD_W-2:0];
      color6   = {quant_chan(req_color_rgb[23:16]),
                  quant_chan(req_color_rgb[15:8]),
                  quant_chan(req_color_rgb[7:0])};
      base_in  = AddrW'(AddrW'(req_pixel_col[COORD_W-2:0]) * RowsA);
   end

   assign op_fire   = s0_valid_ff && op_ready;
   assign req_ready = !clearing && (!s0_valid_ff || (op_fire && phase_ff));
   assign req_fire  = req_valid && req_ready;

   // Advance the two-beat sequence, drop off-grid pixels at intake
   always_comb begin
      s0_valid_in = s0_valid_ff;
      phase_in    = phase_ff;
      if (req_fire) begin
         s0_valid_in = pix_ok;
         phase_in    = 1'b0;
      end else if (op_fire) begin
         s0_valid_in = !phase_ff;
         phase_in    = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         phase_ff    <= phase_in;
      end
   end

   // Hold the decoded pixel
   always_ff @(posedge clock) begin
      if (req_fire) begin
         base_ff     <= base_in;
         half_row_ff <= flip_row[COORD_W-2:1];
         high_ff     <= !flip_row[0];
         lsb_ff      <= color6 & PLANE_LO_MASK;
         msb_ff      <= (color6 & PLANE_HI_MASK) >> 1;
      end
   end

   // Present the current byte update
   always_comb begin
      op_valid         = s0_valid_ff;
      op_addr          = base_ff + AddrW'(half_row_ff) + (phase_ff ? HalfRows : '0);
      op_ctl.last      = phase_ff;
      op_ctl.high_half = high_ff;
      op_ctl.plane     = phase_ff ? msb_ff : lsb_ff;
   end

endmodule

/* rtl/ptbf_store.sv */
// Native store: synchronous memory, clearing sweep, read-modify-write with bypass.
module ptbf_store #(
   parameter int COLS  = 144,
   parameter int ROWS  = 168,
   parameter int AddrW = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   output logic                            clearing,
   input  logic                            op_valid,
   output logic                            op_ready,
   input  logic [AddrW-1:0]                op_addr,
   input  ptbf_pkg::op_ctl_type            op_ctl,
   input  logic                            out_free,
   output logic                            res_valid,
   output logic [AddrW-1:0]                res_addr,
   output logic [ptbf_pkg::WDATA_W-1:0]    res_data,
   output logic                            res_last
);
   import ptbf_pkg::*;

   localparam int               Depth   = COLS * ROWS;
   localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

   logic [WDATA_W-1:0] store_mem [0:Depth-1];

   logic               clear_ff, clear_in;
   logic [AddrW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [AddrW-1:0]   s1_addr_ff;
   op_ctl_type         s1_ctl_ff;
   logic [WDATA_W-1:0] rd_data_ff;
   logic               byp_valid_ff, byp_valid_in;
   logic [AddrW-1:0]   byp_addr_ff;
   logic [WDATA_W-1:0] byp_data_ff;

   logic               op_fire, s1_fire;
   logic [WDATA_W-1:0] old_byte, keep_mask, put_bits, merged;

   assign clearing = clear_ff;
   assign op_ready = !clear_ff && (!s1_valid_ff || out_free);
   assign op_fire  = op_valid && op_ready;
   assign s1_fire  = s1_valid_ff && out_free;

   // Merge the new plane bits into the byte, taking the last write if it hit the same byte
   always_comb begin
      old_byte  = (byp_valid_ff && (byp_addr_ff == s1_addr_ff)) ? byp_data_ff : rd_data_ff;
      keep_mask = s1_ctl_ff.high_half ? PLANE_LO_MASK : PLANE_HI_MASK;
      put_bits  = s1_ctl_ff.high_half ? (s1_ctl_ff.plane << 1) : s1_ctl_ff.plane;
      merged    = (old_byte & keep_mask) | put_bits;
   end

   // Next control state
   always_comb begin
      clear_in     = clear_ff;
      clr_cnt_in   = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LastIdx) begin
            clear_in = 1'b0;
         end
      end
      s1_valid_in  = op_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      byp_valid_in = byp_valid_ff || s1_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   // Hold the update in flight and the last byte written
   always_ff @(posedge clock) begin
      if (op_fire) begin
         s1_addr_ff <= op_addr;
         s1_ctl_ff  <= op_ctl;
      end
      if (s1_fire) begin
         byp_addr_ff <= s1_addr_ff;
         byp_data_ff <= merged;
      end
   end

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         store_mem[clr_cnt_ff] <= '0;
      end else if (s1_fire) begin
         store_mem[s1_addr_ff] <= merged;
      end
      if (op_fire) begin
         rd_data_ff <= store_mem[op_addr];
      end
   end

   assign res_valid = s1_valid_ff;
   assign res_addr  = s1_addr_ff;
   assign res_data  = merged;
   assign res_last  = s1_ctl_ff.last;

endmodule

/* sim/pixel_to_bitplane_framebuffer_checker.sv */
// Checker for the pixel to bit-plane framebuffer: predicts each byte write and compares beats.
module pixel_to_bitplane_framebuffer_checker #(
   parameter int COLS = 144,
   parameter int ROWS = 168
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_col,
   input  logic signed [ptbf_pkg::COORD_W-1:0] req_pixel_row,
   input  logic        [ptbf_pkg::COLOR_W-1:0] req_color_rgb,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic        [ptbf_pkg::WADDR_W-1:0] rsp_write_addr,
   input  logic        [ptbf_pkg::WDATA_W-1:0] rsp_write_data,
   input  logic                                rsp_last_write,
   output int                                  mismatch_count,
   output int                                  beats_pending
);

   import ptbf_pkg::*;

   localparam int DEPTH = COLS * ROWS;

   typedef struct {
      logic [WADDR_W-1:0] addr;
      logic [WDATA_W-1:0] data;
      logic               last;
   } byte_write_type;

   // Model copy of the native store and the byte writes still owed by the block
   logic [WDATA_W-1:0] plane_store [DEPTH];
   byte_write_type     owed_writes [$];
   byte_write_type     oldest;
   int                 beat_no;

   // Merge one pixel's plane bits into its byte, keeping the neighbour row's bits
   function automatic logic [WDATA_W-1:0] merge_plane(input int addr,
                                                      input logic [WDATA_W-1:0] bits,
                                                      input logic upper);
      logic [WDATA_W-1:0] keep;
      logic [WDATA_W-1:0] put;
      logic [WDATA_W-1:0] merged;
      keep   = upper ? PLANE_LO_MASK : PLANE_HI_MASK;
      put    = upper ? (bits << 1) : bits;
      merged = (plane_store[addr] & keep) | put;
      plane_store[addr] = merged;
      return merged;
   endfunction

   // Work out the two byte writes of an on-grid pixel; drop anything off the grid
   task automatic predict_pixel(input logic signed [COORD_W-1:0] col,
                                input logic signed [COORD_W-1:0] row,
                                input logic [COLOR_W-1:0] rgb);
      int                 c;
      int                 r;
      int                 flipped;
      int                 base;
      logic [7:0]         qr;
      logic [7:0]         qg;
      logic [7:0]         qb;
      logic [WDATA_W-1:0] colour;
      logic [WDATA_W-1:0] lo_bits;
      logic [WDATA_W-1:0] hi_bits;
      logic               even_row;
      byte_write_type     w;
      c = col;
      r = row;
      if (c >= 0 && c < COLS && r >= 0 && r < ROWS) begin
         qr       = rgb[23:16] / CHAN_STEP;
         qg       = rgb[15:8] / CHAN_STEP;
         qb       = rgb[7:0] / CHAN_STEP;
         colour   = {qr[1:0], qg[1:0], qb[1:0]};
         lo_bits  = colour & PLANE_LO_MASK;
         hi_bits  = (colour & PLANE_HI_MASK) >> 1;
         flipped  = ROWS - 1 - r;
         even_row = (flipped % 2) == 0;
         base     = c * ROWS;
         w.addr   = WADDR_W'(base + flipped / 2);
         w.data   = merge_plane(base + flipped / 2, lo_bits, even_row);
         w.last   = 1'b0;
         owed_writes.push_back(w);
         w.addr   = WADDR_W'(base + ROWS / 2 + flipped / 2);
         w.data   = merge_plane(base + ROWS / 2 + flipped / 2, hi_bits, even_row);
         w.last   = 1'b1;
         owed_writes.push_back(w);
      end
   endtask

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on write beat %0d: %s", beat_no, what);
      end
   endtask

   // Compare the result beat first, then take the pixel beat of the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) plane_store[i] = '0;
         owed_writes.delete();
         mismatch_count = 0;
         beats_pending  = 0;
         beat_no        = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_writes.size() == 0) begin
               log_mismatch($sformatf("unexpected beat addr %0d data %02h last %0b",
                                      rsp_write_addr, rsp_write_data, rsp_last_write));
            end else begin
               oldest = owed_writes.pop_front();
               if (rsp_write_addr !== oldest.addr || rsp_write_data !== oldest.data ||
                   rsp_last_write !== oldest.last) begin
                  log_mismatch($sformatf(
                     "addr exp %0d got %0d, data exp %02h got %02h, last exp %0b got %0b",
                     oldest.addr, rsp_write_addr, oldest.data, rsp_write_data,
                     oldest.last, rsp_last_write));
               end
            end
            beat_no++;
         end
         if (req_valid && req_ready) begin
            predict_pixel(req_pixel_col, req_pixel_row, req_color_rgb);
         end
         beats_pending = owed_writes.size();
      end
   end

endmodule

/* sim/pixel_to_bitplane_framebuffer_test.sv */
// Testbench top for the pixel to bit-plane framebuffer: stimulus, flow control and verdict.
module pixel_to_bitplane_framebuffer_test;

   import ptbf_pkg::*;

   localparam int COLS        = 144;
   localparam int ROWS        = 168;
   localparam int GRID_ITEMS  = 1100;
   localparam int CYCLE_LIMIT = 300000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_pixel_col;
   logic signed [COORD_W-1:0] req_pixel_row;
   logic        [COLOR_W-1:0] req_color_rgb;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic        [WADDR_W-1:0] rsp_write_addr;
   logic        [WDATA_W-1:0] rsp_write_data;
   logic                      rsp_last_write;

   int fail_count;
   int beats_left;
   int pixels_sent;
   int cycles;
   int hold_left;
   bit held_off;

   pixel_to_bitplane_framebuffer #(.COLS(COLS), .ROWS(ROWS)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_color_rgb  (req_color_rgb),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_data (rsp_write_data),
      .rsp_last_write (rsp_last_write)
   );

   pixel_to_bitplane_framebuffer_checker #(.COLS(COLS), .ROWS(ROWS)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .req_color_rgb  (req_color_rgb),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_data (rsp_write_data),
      .rsp_last_write (rsp_last_write),
      .mismatch_count (fail_count),
      .beats_pending  (beats_left)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Channel values around the quantisation steps, or anything at all
   function automatic logic [7:0] boundary_chan();
      logic [7:0] v;
      case ($urandom_range(0, 7))
         0: v = 8'd0;
         1: v = 8'd84;
         2: v = 8'd85;
         3: v = 8'd169;
         4: v = 8'd170;
         5: v = 8'd254;
         6: v = 8'd255;
         default: v = 8'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [COLOR_W-1:0] some_colour();
      logic [COLOR_W-1:0] c;
      if ($urandom_range(0, 1) == 0) begin
         c = COLOR_W'($urandom);
      end else begin
         c = {boundary_chan(), boundary_chan(), boundary_chan()};
      end
      return c;
   endfunction

   // Offer one pixel beat, with random gaps ahead of it outside pixels 300 to 449, and hold it until taken
   task automatic send_pixel(input logic signed [COORD_W-1:0] col,
                             input logic signed [COORD_W-1:0] row,
                             input logic [COLOR_W-1:0] rgb);
      @(negedge clock);
      while (!(pixels_sent >= 300 && pixels_sent < 450) && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      req_color_rgb <= rgb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   // Result side: random stalls, a quiet stretch, and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      held_off  = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && pixels_sent >= 800) begin
            held_off  = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (pixels_sent >= 500 && pixels_sent < 650) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Run watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** pixel_to_bitplane_framebuffer: FAILED **");
      $finish;
   end

   initial begin
      int grid_sent;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      int pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      req_color_rgb = '0;
      pixels_sent   = 0;
      grid_sent     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: row pairs sharing a byte, corners, channel steps, off-grid drops
      send_pixel(0, 0, 24'hFFFFFF);
      send_pixel(0, 1, 24'hFFFFFF);
      send_pixel(0, 1, 24'h000000);
      send_pixel(0, 0, 24'h55AA55);
      send_pixel(143, 167, 24'h55AAFF);
      send_pixel(143, 166, 24'h54A9FE);
      send_pixel(1, 10, 24'hFF0000);
      send_pixel(1, 10, 24'h00FF00);
      send_pixel(1, 11, 24'h0000FF);
      send_pixel(72, 84, 24'h55AA55);
      send_pixel(72, 85, 24'hAA55AA);
      send_pixel(143, 0, 24'h000000);
      send_pixel(0, 167, 24'hFFFFFF);
      send_pixel(-1, 5, 24'hFFFFFF);
      send_pixel(144, 5, 24'hFFFFFF);
      send_pixel(5, -1, 24'hFFFFFF);
      send_pixel(5, 168, 24'hFFFFFF);
      send_pixel(-512, -512, 24'hFFFFFF);
      send_pixel(511, 511, 24'hFFFFFF);
      send_pixel(-512, 0, 24'h123456);
      send_pixel(0, 511, 24'hABCDEF);
      send_pixel(143, 1, 24'hA9AAFF);

      // Random: mostly on-grid pixels, a share packed into a few columns so bytes get reused
      while (grid_sent < GRID_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            col = COORD_W'($urandom);
            row = COORD_W'($urandom);
         end else begin
            if (pick < 55) begin
               col = ($urandom_range(0, 1) == 0) ? COORD_W'($urandom_range(0, 2))
                                                 : COORD_W'($urandom_range(COLS - 3, COLS - 1));
            end else begin
               col = COORD_W'($urandom_range(0, COLS - 1));
            end
            row = COORD_W'($urandom_range(0, ROWS - 1));
         end
         grid_sent++;
         send_pixel(col, row, some_colour());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the owed writes, then let the pipeline settle
      while (beats_left != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (fail_count == 0 && beats_left == 0) begin
         $display("** pixel_to_bitplane_framebuffer: PASSED **");
      end else begin
         $display("** pixel_to_bitplane_framebuffer: FAILED **");
      end
      $finish;
   end

endmodule
